[rtl/dsm_pkg.sv]
package dsm_pkg;

  localparam int unsigned PAT_MAX_DEF = 16;

  localparam logic [7:0] CH_ANY  = 8'h2E;
  localparam logic [7:0] CH_STAR = 8'h2A;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_END     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_WRITE = 3'd2,
    OP_STAR  = 3'd3,
    OP_TEXT  = 3'd4,
    OP_ARM   = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] ch;
  } cell_cmd_t;

  typedef struct packed {
    logic carry;
    logic adv;
  } cell_link_t;

endpackage

[rtl/dsm_cell.sv]
module dsm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsm_pkg::cell_cmd_t cmd_i,
  input  logic               wr_sel_i,
  input  logic               star_sel_i,
  input  dsm_pkg::cell_link_t link_i,
  output dsm_pkg::cell_link_t link_o,
  output logic               closure_o,
  output logic               starred_o
);

  logic [7:0] char_q, char_d;
  logic       star_q, star_d;
  logic       used_q, used_d;
  logic       act_q, act_d;
  logic       closure;
  logic       hit;

  assign closure = act_q | link_i.carry;
  assign hit     = used_q & ((char_q == cmd_i.ch) | (char_q == dsm_pkg::CH_ANY));

  assign link_o.carry = closure & star_q;
  assign link_o.adv   = hit & closure & ~star_q;
  assign closure_o    = closure;
  assign starred_o    = star_q;

  always_comb begin
    char_d = char_q;
    star_d = star_q;
    used_d = used_q;
    act_d  = act_q;
    case (cmd_i.op)
      dsm_pkg::OP_CLEAR: begin
        star_d = 1'b0;
        used_d = 1'b0;
        act_d  = FIRST;
      end
      dsm_pkg::OP_WRITE: begin
        if (wr_sel_i) begin
          char_d = cmd_i.ch;
          star_d = 1'b0;
          used_d = 1'b1;
        end
      end
      dsm_pkg::OP_STAR: begin
        if (star_sel_i) begin
          star_d = 1'b1;
        end
      end
      dsm_pkg::OP_TEXT: begin
        act_d = (hit & closure & star_q) | link_i.adv;
      end
      dsm_pkg::OP_ARM: begin
        act_d = FIRST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_q <= 1'b0;
      used_q <= 1'b0;
      act_q  <= FIRST;
    end else begin
      star_q <= star_d;
      used_q <= used_d;
      act_q  <= act_d;
    end
  end

endmodule

[rtl/dot_star_pattern_matcher_top.sv]
// The result of an end-of-text word is registered and valid in the cycle after the word is accepted.
// Throughput: one word per cycle; an end-of-text word waits only while an unread result is held.
// The per-byte update ripples the skip over starred elements through the row of cells.
// Reset is asynchronous and active low; it empties the pattern and arms position zero.
// A clear-job word does the same at run time; no clearing pass is needed.
module dot_star_pattern_matcher_top #(
  parameter int unsigned PAT_MAX = dsm_pkg::PAT_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       overflow_o
);

  localparam int unsigned CW = $clog2(PAT_MAX + 1);

  dsm_pkg::mode_e      mode;
  dsm_pkg::cell_cmd_t  cmd;
  dsm_pkg::cell_link_t links [PAT_MAX+1];

  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               tail_q, tail_d;
  logic               out_valid_q, out_valid_d;
  logic               matched_q, matched_d;
  logic               ovf_out_q, ovf_out_d;
  logic [PAT_MAX-1:0] wr_sel, star_sel, starred;
  logic [PAT_MAX:0]   closure;
  logic               last_starred;
  logic               in_acc;
  logic               out_free;

  assign mode     = dsm_pkg::mode_e'(mode_i);
  assign out_free = ~out_valid_q | out_ready_i;
  assign in_ready_o = (mode != dsm_pkg::MODE_END) | out_free;
  assign in_acc   = in_valid_i & in_ready_o;

  assign links[0].carry = 1'b0;
  assign links[0].adv   = 1'b0;

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    assign wr_sel[i]   = (count_q == CW'(i));
    assign star_sel[i] = (count_q == CW'(i + 1));

    dsm_cell #(
      .FIRST(i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .wr_sel_i   (wr_sel[i]),
      .star_sel_i (star_sel[i]),
      .link_i     (links[i]),
      .link_o     (links[i+1]),
      .closure_o  (closure[i]),
      .starred_o  (starred[i])
    );
  end

  assign closure[PAT_MAX] = tail_q | links[PAT_MAX].carry;
  assign last_starred     = |(starred & star_sel);

  always_comb begin
    cmd.op  = dsm_pkg::OP_IDLE;
    cmd.ch  = char_code_i;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (in_acc) begin
      case (mode)
        dsm_pkg::MODE_CLEAR: begin
          cmd.op  = dsm_pkg::OP_CLEAR;
          count_d = '0;
          ovf_d   = 1'b0;
        end
        dsm_pkg::MODE_PATTERN: begin
          if (!ovf_q) begin
            if (char_code_i == dsm_pkg::CH_STAR && count_q != '0 && !last_starred) begin
              cmd.op = dsm_pkg::OP_STAR;
            end else if (count_q == CW'(PAT_MAX)) begin
              ovf_d = 1'b1;
            end else begin
              cmd.op  = dsm_pkg::OP_WRITE;
              count_d = count_q + CW'(1);
            end
          end
        end
        dsm_pkg::MODE_TEXT: begin
          cmd.op = dsm_pkg::OP_TEXT;
        end
        dsm_pkg::MODE_END: begin
          cmd.op = dsm_pkg::OP_ARM;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tail_d = tail_q;
    case (cmd.op)
      dsm_pkg::OP_CLEAR, dsm_pkg::OP_ARM: tail_d = 1'b0;
      dsm_pkg::OP_TEXT:                   tail_d = links[PAT_MAX].adv;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    ovf_out_d   = ovf_out_q;
    if (in_acc && mode == dsm_pkg::MODE_END) begin
      out_valid_d = 1'b1;
      matched_d   = closure[count_q] & ~ovf_q;
      ovf_out_d   = ovf_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = ovf_out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PAT_MAX))
    else $error("element count beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CW'(PAT_MAX))
    else $error("overflow set with free elements");

  a_no_match_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(matched_q && ovf_out_q))
    else $error("match reported with overflow");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode == dsm_pkg::MODE_END) |=> out_valid_q)
    else $error("end word gave no result");

endmodule

[verif/dot_star_pattern_matcher_top_test.sv]
`timescale 1ns / 1ps

module dot_star_pattern_matcher_top_test;

  localparam int unsigned PAT_MAX = dsm_pkg::PAT_MAX_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 20;

  typedef struct {
    dsm_pkg::mode_e mode;
    logic [7:0] code;
  } word_t;

  typedef struct {
    logic matched;
    logic overflow;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  dsm_pkg::mode_e in_mode = dsm_pkg::MODE_CLEAR;
  logic [7:0] in_code = 8'h00;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic matched_o;
  logic overflow_o;
  logic no_idle = 1'b0;

  word_t word_q[$];
  verdict_t verdict_q[$];
  verdict_t head_verdict;
  word_t next_word;
  int mismatches = 0;
  int results_seen = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit held = 1'b0;

  // Shadow copy of the matcher state.
  logic [7:0] elem_chars[PAT_MAX];
  logic [PAT_MAX-1:0] elem_starred;
  int unsigned elem_count;
  logic [PAT_MAX:0] live_pos;
  logic pat_overflow;

  dot_star_pattern_matcher_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .mode_i     (in_mode),
    .char_code_i(in_code),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .matched_o  (matched_o),
    .overflow_o (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_job();
    for (int i = 0; i < PAT_MAX; i++) begin
      elem_chars[i] = 8'h00;
    end
    elem_starred = '0;
    elem_count = 0;
    pat_overflow = 1'b0;
    live_pos = (PAT_MAX + 1)'(1);
  endfunction

  // Positions reachable by skipping starred elements.
  function automatic logic [PAT_MAX:0] skip_starred();
    logic [PAT_MAX:0] c;
    c = live_pos;
    for (int i = 0; i < elem_count; i++) begin
      if (c[i] && elem_starred[i]) c[i+1] = 1'b1;
    end
    return c;
  endfunction

  function automatic void apply_word(dsm_pkg::mode_e m, logic [7:0] b);
    logic [PAT_MAX:0] c;
    logic [PAT_MAX:0] nxt;
    verdict_t v;
    case (m)
      dsm_pkg::MODE_CLEAR: begin
        clear_job();
      end
      dsm_pkg::MODE_PATTERN: begin
        if (!pat_overflow) begin
          if (b == dsm_pkg::CH_STAR && elem_count > 0 && !elem_starred[elem_count-1]) begin
            elem_starred[elem_count-1] = 1'b1;
          end else if (elem_count >= PAT_MAX) begin
            pat_overflow = 1'b1;
          end else begin
            elem_chars[elem_count] = b;
            elem_starred[elem_count] = 1'b0;
            elem_count++;
          end
        end
      end
      dsm_pkg::MODE_TEXT: begin
        c = skip_starred();
        nxt = '0;
        for (int i = 0; i < elem_count; i++) begin
          if (c[i] && (elem_chars[i] == b || elem_chars[i] == dsm_pkg::CH_ANY)) begin
            if (elem_starred[i]) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      default: begin
        c = skip_starred();
        v.matched = c[elem_count] && !pat_overflow;
        v.overflow = pat_overflow;
        verdict_q.push_back(v);
        live_pos = (PAT_MAX + 1)'(1);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return "a";
    if (r < 7) return "b";
    if (r < 8) return dsm_pkg::CH_ANY;
    if (r < 9) return dsm_pkg::CH_STAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_word(dsm_pkg::mode_e m, logic [7:0] b);
    word_t w;
    w.mode = m;
    w.code = b;
    word_q.push_back(w);
  endfunction

  // One job: optional random words, an optional clear, a pattern, then one to four texts each closed by an end word.
  function automatic void add_job();
    logic [7:0] el_ch[$];
    bit el_star[$];
    logic [7:0] txt[$];
    logic [7:0] ch;
    int n;
    int reps;
    int pos;
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        push_word(dsm_pkg::mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
    if ($urandom_range(0, 9) != 0) push_word(dsm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      ch = pick_char();
      if (ch == dsm_pkg::CH_STAR && i > 0 && !el_star[i-1]) ch = "a";
      el_ch.push_back(ch);
      el_star.push_back($urandom_range(0, 9) < 3);
      push_word(dsm_pkg::MODE_PATTERN, ch);
      if (el_star[i]) push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_STAR);
    end
    repeat ($urandom_range(1, 4)) begin
      txt.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 5)) txt.push_back(pick_char());
      end else begin
        for (int i = 0; i < el_ch.size(); i++) begin
          reps = el_star[i] ? $urandom_range(0, 3) : 1;
          repeat (reps) txt.push_back(el_ch[i] == dsm_pkg::CH_ANY ? pick_char() : el_ch[i]);
        end
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, txt.size());
          case ($urandom_range(0, 2))
            0: if (pos < txt.size()) txt[pos] = pick_char();
            1: if (pos < txt.size()) txt.delete(pos);
            default: txt.insert(pos, pick_char());
          endcase
        end
      end
      if ($urandom_range(0, 19) == 0) push_word(dsm_pkg::MODE_PATTERN, pick_char());
      foreach (txt[i]) push_word(dsm_pkg::MODE_TEXT, txt[i]);
      push_word(dsm_pkg::MODE_END, 8'($urandom_range(0, 255)));
    end
  endfunction

  always @(posedge clk_i) begin
    if ($urandom_range(0, 149) == 0) no_idle <= !no_idle;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_mode <= dsm_pkg::MODE_CLEAR;
      in_code <= 8'h00;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        apply_word(in_mode, in_code);
        in_gap = pick_gap();
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          next_word = word_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= next_word.mode;
          in_code <= next_word.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result with no verdict pending: matched=%0b overflow=%0b",
                 matched_o, overflow_o);
          mismatches++;
        end else begin
          head_verdict = verdict_q.pop_front();
          if (matched_o !== head_verdict.matched) begin
            $error("matched: expected %0b, actual %0b", head_verdict.matched, matched_o);
            mismatches++;
          end
          if (overflow_o !== head_verdict.overflow) begin
            $error("overflow: expected %0b, actual %0b", head_verdict.overflow, overflow_o);
            mismatches++;
          end
        end
        // Hold the result side off once so the block backs up and stalls its input.
        if (!held && results_seen == HOLD_AFTER) begin
          held = 1'b1;
          out_gap = HOLD_CYCLES;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clear_job();
    push_word(dsm_pkg::MODE_END, 8'h00);
    push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_PATTERN, 8'h00);
    push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_ANY);
    push_word(dsm_pkg::MODE_PATTERN, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_PATTERN, 8'hFF);
    push_word(dsm_pkg::MODE_TEXT, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_TEXT, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_TEXT, dsm_pkg::CH_STAR);
    push_word(dsm_pkg::MODE_TEXT, 8'h00);
    push_word(dsm_pkg::MODE_TEXT, "q");
    push_word(dsm_pkg::MODE_TEXT, 8'h00);
    push_word(dsm_pkg::MODE_TEXT, 8'hFF);
    push_word(dsm_pkg::MODE_END, 8'hFF);
    push_word(dsm_pkg::MODE_TEXT, 8'hFF);
    push_word(dsm_pkg::MODE_END, 8'h00);
    push_word(dsm_pkg::MODE_CLEAR, 8'hFF);
    push_word(dsm_pkg::MODE_TEXT, "a");
    push_word(dsm_pkg::MODE_PATTERN, "a");
    push_word(dsm_pkg::MODE_END, 8'h00);
    while (word_q.size() < 1220) add_job();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
